// ----- src/lbof_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbof_pkg: shared types, constants and pair rules
// Class codes, offset masking and the pair decision for the line-break
// opportunity finder.
// ----------------------------------------------------------------------------
package lbof_pkg;

  // Field widths
  localparam int CLASS_W  = 6;
  localparam int OFFSET_W = 16;

  // Bits of the offset that are kept (8..32)
  localparam int OFFSET_BITS = 16;
  localparam logic [OFFSET_W-1:0] OFF_MASK =
    (OFFSET_BITS >= OFFSET_W) ? {OFFSET_W{1'b1}}
                              : OFFSET_W'((64'd1 << OFFSET_BITS) - 64'd1);

  typedef logic [CLASS_W-1:0]  lb_class_t;
  typedef logic [OFFSET_W-1:0] lb_offset_t;

  // Line-break class codes; 36..63 match no rule
  localparam lb_class_t K_BK = 6'd0;
  localparam lb_class_t K_CR = 6'd1;
  localparam lb_class_t K_LF = 6'd2;
  localparam lb_class_t K_NL = 6'd3;
  localparam lb_class_t K_SP = 6'd4;
  localparam lb_class_t K_ZW = 6'd5;
  localparam lb_class_t K_WJ = 6'd6;
  localparam lb_class_t K_GL = 6'd7;
  localparam lb_class_t K_BA = 6'd8;
  localparam lb_class_t K_HY = 6'd9;
  localparam lb_class_t K_CL = 6'd10;
  localparam lb_class_t K_CP = 6'd11;
  localparam lb_class_t K_EX = 6'd12;
  localparam lb_class_t K_IS = 6'd13;
  localparam lb_class_t K_SY = 6'd14;
  localparam lb_class_t K_OP = 6'd15;
  localparam lb_class_t K_QU = 6'd16;
  localparam lb_class_t K_NS = 6'd17;
  localparam lb_class_t K_B2 = 6'd18;
  localparam lb_class_t K_IN = 6'd19;
  localparam lb_class_t K_AL = 6'd20;
  localparam lb_class_t K_AI = 6'd21;
  localparam lb_class_t K_SA = 6'd22;
  localparam lb_class_t K_NU = 6'd23;
  localparam lb_class_t K_PR = 6'd24;
  localparam lb_class_t K_PO = 6'd25;
  localparam lb_class_t K_ID = 6'd26;
  localparam lb_class_t K_EB = 6'd27;
  localparam lb_class_t K_EM = 6'd28;
  localparam lb_class_t K_JL = 6'd29;
  localparam lb_class_t K_JV = 6'd30;
  localparam lb_class_t K_JT = 6'd31;
  localparam lb_class_t K_H2 = 6'd32;
  localparam lb_class_t K_H3 = 6'd33;
  localparam lb_class_t K_CM = 6'd34;
  localparam lb_class_t K_CJ = 6'd35;

  // Class sets as bit masks, one bit per class code
  localparam logic [63:0] SET_LETTERS = (64'd1 << K_AL) | (64'd1 << K_AI) | (64'd1 << K_SA);
  localparam logic [63:0] SET_EMOJI   = (64'd1 << K_ID) | (64'd1 << K_EB) | (64'd1 << K_EM);
  localparam logic [63:0] SET_HARD    = (64'd1 << K_BK) | (64'd1 << K_CR) |
                                        (64'd1 << K_LF) | (64'd1 << K_NL);
  localparam logic [63:0] SET_CLOSE   = (64'd1 << K_CL) | (64'd1 << K_CP) | (64'd1 << K_EX) |
                                        (64'd1 << K_IS) | (64'd1 << K_SY);
  localparam logic [63:0] SET_ALNUM   = (64'd1 << K_AL) | (64'd1 << K_AI) | (64'd1 << K_NU);
  localparam logic [63:0] SET_JL_NEXT = (64'd1 << K_JL) | (64'd1 << K_JV) |
                                        (64'd1 << K_H2) | (64'd1 << K_H3);

  // Pair decision
  typedef enum logic [1:0] {
    ACT_NO,
    ACT_MAY,
    ACT_MUST
  } lb_act_t;

  function automatic lb_class_t resolve_class(input lb_class_t k);
    return (k == K_CJ) ? K_NS : k;
  endfunction

  function automatic logic in_set(input lb_class_t k, input logic [63:0] set);
    return set[k];
  endfunction

  // b: class before the break, a: class after it (both resolved)
  function automatic lb_act_t pair_action(input lb_class_t b, input lb_class_t a);
    lb_act_t act;
    act = ACT_MAY;
    if (b == K_BK || b == K_LF || b == K_NL) act = ACT_MUST;
    else if (b == K_CR) act = (a == K_LF) ? ACT_NO : ACT_MUST;
    else if (in_set(a, SET_HARD)) act = ACT_NO;
    else if (a == K_SP || a == K_ZW) act = ACT_NO;
    else if (b == K_ZW) act = ACT_MAY;
    else if (a == K_WJ || b == K_WJ) act = ACT_NO;
    else if (b == K_GL) act = ACT_NO;
    else if (a == K_GL && b != K_SP && b != K_BA && b != K_HY) act = ACT_NO;
    else if (in_set(a, SET_CLOSE)) act = ACT_NO;
    else if (b == K_OP) act = ACT_NO;
    else if (b == K_QU && a == K_OP) act = ACT_NO;
    else if (b == K_CL && a == K_NS) act = ACT_NO;
    else if (b == K_B2 && a == K_B2) act = ACT_NO;
    else if (b == K_SP) act = ACT_MAY;
    else if (a == K_QU || b == K_QU) act = ACT_NO;
    else if (b == K_B2 || a == K_B2) act = ACT_MAY;
    else if (a == K_BA || a == K_HY || a == K_NS) act = ACT_NO;
    else if (b == K_HY || b == K_BA) act = ACT_MAY;
    else if (a == K_IN) act = ACT_NO;
    else if (in_set(b, SET_LETTERS) && a == K_NU) act = ACT_NO;
    else if (b == K_NU && in_set(a, SET_LETTERS)) act = ACT_NO;
    else if (b == K_PR && in_set(a, SET_EMOJI)) act = ACT_NO;
    else if (in_set(b, SET_EMOJI) && a == K_PO) act = ACT_NO;
    else if ((b == K_PR || b == K_PO) && in_set(a, SET_ALNUM)) act = ACT_NO;
    else if (in_set(b, SET_ALNUM) && a == K_PO) act = ACT_NO;
    else if (b == K_NU && (a == K_NU || a == K_IS || a == K_SY)) act = ACT_NO;
    else if ((b == K_IS || b == K_SY) && a == K_NU) act = ACT_NO;
    else if (b == K_CL && a == K_PO) act = ACT_NO;
    else if (b == K_JL && in_set(a, SET_JL_NEXT)) act = ACT_NO;
    else if ((b == K_JV || b == K_H2) && (a == K_JV || a == K_JT)) act = ACT_NO;
    else if ((b == K_JT || b == K_H3) && a == K_JT) act = ACT_NO;
    else if (in_set(b, SET_LETTERS | (64'd1 << K_CM)) && in_set(a, SET_LETTERS)) act = ACT_NO;
    else if (b == K_IS && (a == K_AL || a == K_AI)) act = ACT_NO;
    else if (in_set(b, SET_ALNUM) && a == K_OP) act = ACT_NO;
    else if (b == K_CP && in_set(a, SET_ALNUM)) act = ACT_NO;
    else if (b == K_EB && a == K_EM) act = ACT_NO;
    return act;
  endfunction

endpackage

// ----- src/lbof_char_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbof_char_if: character channel
// Valid/ready channel carrying one classified character per transaction.
// ----------------------------------------------------------------------------
interface lbof_char_if import lbof_pkg::*; ();
  logic       valid;
  logic       ready;
  lb_class_t  char_class;
  lb_offset_t end_offset;
  logic       text_start;

  modport source (output valid, char_class, end_offset, text_start, input ready);
  modport sink   (input valid, char_class, end_offset, text_start, output ready);
endinterface

// ----- src/lbof_break_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbof_break_if: break channel
// Valid/ready channel carrying one break opportunity per transaction.
// ----------------------------------------------------------------------------
interface lbof_break_if import lbof_pkg::*; ();
  logic       valid;
  logic       ready;
  lb_offset_t break_offset;
  logic       mandatory;

  modport source (output valid, break_offset, mandatory, input ready);
  modport sink   (input valid, break_offset, mandatory, output ready);
endinterface

// ----- src/line_break_opportunity_finder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_break_opportunity_finder: pair-table line break finder
// Compares each character's class with the previous one and reports the
// previous end offset as an allowed or mandatory break.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                               | per transaction
//  ---------+-----+---------------------------------------+------------------
//  chars    | in  | char_class, end_offset, text_start    | one character
//  breaks   | out | break_offset, mandatory               | zero or one break
//
//  One character per cycle while chars.ready is high; a break is registered
//  when its character is accepted. The rate is set by the combinational
//  pair lookup between the previous-character registers and the result
//  register. A two-entry output buffer (result register plus skid) holds
//  one more break during an output stall; chars.ready drops only when the
//  skid entry is occupied. Synchronous reset clears the previous character.
// ----------------------------------------------------------------------------
module line_break_opportunity_finder import lbof_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  lbof_char_if.sink    chars,
  lbof_break_if.source breaks
);

  // Previous character state
  lb_class_t  prev_class;
  lb_offset_t prev_end;
  logic       have_prev;

  // Output buffer
  logic       out_valid;
  lb_offset_t out_offset;
  logic       out_mand;
  logic       skid_valid;
  lb_offset_t skid_offset;
  logic       skid_mand;

  logic       accept;
  logic       pop;
  logic       prev_ok;
  logic       is_cm;
  logic       emit;
  lb_offset_t cur_off;
  lb_act_t    act;

  assign chars.ready = ~skid_valid;
  assign accept      = chars.valid & chars.ready;
  assign pop         = out_valid & breaks.ready;

  // Pair decision against the stored character
  always_comb begin
    cur_off = chars.end_offset & OFF_MASK;
    prev_ok = have_prev & ~chars.text_start;
    is_cm   = (chars.char_class == K_CM);
    act     = pair_action(resolve_class(prev_class), resolve_class(chars.char_class));
    emit    = accept & prev_ok & ~is_cm & (act != ACT_NO);
  end

  // Previous character update; a trailing mark only moves the end offset
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_class <= K_BK;
      prev_end   <= '0;
      have_prev  <= 1'b0;
    end else if (accept) begin
      prev_end  <= cur_off;
      have_prev <= 1'b1;
      if (!(prev_ok && is_cm)) begin
        prev_class <= chars.char_class;
      end
    end
  end

  // Result register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= emit;
      end else begin
        out_valid  <= emit;
      end
    end else if (emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_offset  <= skid_offset;
        out_mand    <= skid_mand;
        skid_offset <= prev_end;
        skid_mand   <= (act == ACT_MUST);
      end else begin
        out_offset  <= prev_end;
        out_mand    <= (act == ACT_MUST);
      end
    end else if (emit) begin
      skid_offset <= prev_end;
      skid_mand   <= (act == ACT_MUST);
    end
  end

  assign breaks.valid        = out_valid;
  assign breaks.break_offset = out_offset;
  assign breaks.mandatory    = out_mand;

  // Checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while result register empty");

  a_have_prev_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> have_prev)
    else $error("previous character not recorded");

  a_mark_keeps_class: assert property (@(posedge clk) disable iff (rst)
    accept && prev_ok && is_cm |=> prev_class == $past(prev_class))
    else $error("combining mark changed previous class");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    emit && out_valid && !breaks.ready |=> skid_valid)
    else $error("break lost during output stall");

  a_mark_no_break: assert property (@(posedge clk) disable iff (rst)
    accept && prev_ok && is_cm |-> !emit)
    else $error("break emitted for combining mark");

endmodule
